/* hw/rtl/hs5_pkg.sv */
`timescale 1ns / 1ps

package hs5_pkg;

  localparam int DATA_W       = 32;
  localparam int COEF_W       = 16;
  localparam int GRID_W       = 11;
  localparam int HALO_W       = 4;
  localparam int IDX_W        = 10;
  localparam int PADDR_W      = 5;
  localparam int PDATA_W      = 32;
  localparam int MIN_DIM      = 3;
  localparam int MAX_ROWS_DEF = 1024;
  localparam int MAX_COLS_DEF = 1024;
  localparam int QUEUE_DEPTH  = 4;

  localparam logic [GRID_W-1:0] GRID_RESET = 11'd1024;
  localparam logic [HALO_W-1:0] HALO_RESET = 4'd1;

  // register index = paddr[4:2]
  localparam logic [2:0] REG_COEF_X     = 3'd0;
  localparam logic [2:0] REG_COEF_Y     = 3'd1;
  localparam logic [2:0] REG_GRID_ROWS  = 3'd2;
  localparam logic [2:0] REG_GRID_COLS  = 3'd3;
  localparam logic [2:0] REG_HALO_WIDTH = 3'd4;

  typedef struct packed {
    logic [COEF_W-1:0] coef_x;
    logic [COEF_W-1:0] coef_y;
    logic [GRID_W-1:0] grid_rows;
    logic [GRID_W-1:0] grid_cols;
    logic [HALO_W-1:0] halo_width;
  } cfg_t;

  // one interior point with its four neighbours
  typedef struct packed {
    logic [DATA_W-1:0] sample;
    logic [DATA_W-1:0] above;
    logic [DATA_W-1:0] above2;
    logic [DATA_W-1:0] right_above;
    logic [DATA_W-1:0] left_above;
    logic [IDX_W-1:0]  row;
    logic [IDX_W-1:0]  col;
    logic              last;
  } work_t;

endpackage

/* hw/rtl/heat_stencil_5pt_step.sv */
// A result passes the read stage, the queue and back-end stages a, b and c before it is registered at the output.
// Throughput: one sample per cycle while sample_stall is low; the row-above buffer is
// dual-read single-write, so the row-above pair and row-above-2 are read with the write.
// Reset (rst, synchronous): position counters, queue and valid flags clear, registers
// return to coef 0, grid 1024 x 1024, halo 1. Line buffers are not cleared.
`timescale 1ns / 1ps

module heat_stencil_5pt_step #(
  parameter int MAX_ROWS    = hs5_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS    = hs5_pkg::MAX_COLS_DEF,
  parameter int QUEUE_DEPTH = hs5_pkg::QUEUE_DEPTH
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [hs5_pkg::PADDR_W-1:0]       paddr,
  input  logic [hs5_pkg::PDATA_W-1:0]       pwdata,
  output logic [hs5_pkg::PDATA_W-1:0]       prdata,
  output logic                              pready,
  input  logic signed [hs5_pkg::DATA_W-1:0] sample,
  input  logic                              sample_valid,
  output logic                              sample_stall,
  output logic signed [hs5_pkg::DATA_W-1:0] new_value,
  output logic [hs5_pkg::IDX_W-1:0]         row,
  output logic [hs5_pkg::IDX_W-1:0]         col,
  output logic                              last,
  output logic                              result_valid,
  input  logic                              result_stall
);
  import hs5_pkg::*;

  cfg_t                           cfg;
  work_t                          push_data, pop_data;
  logic                           push, pop, q_empty;
  logic [$clog2(QUEUE_DEPTH+1)-1:0] q_count;

  hs5_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  hs5_front #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS),
    .DEPTH    (QUEUE_DEPTH)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .sample       (sample),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .push         (push),
    .push_data    (push_data),
    .q_count      (q_count)
  );

  hs5_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (q_empty),
    .count     (q_count)
  );

  hs5_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .q_data       (pop_data),
    .q_empty      (q_empty),
    .q_pop        (pop),
    .new_value    (new_value),
    .row          (row),
    .col          (col),
    .last         (last),
    .result_valid (result_valid),
    .result_stall (result_stall)
  );

endmodule

/* hw/rtl/hs5_cfg.sv */
`timescale 1ns / 1ps

module hs5_cfg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [hs5_pkg::PADDR_W-1:0] paddr,
  input  logic [hs5_pkg::PDATA_W-1:0] pwdata,
  output logic [hs5_pkg::PDATA_W-1:0] prdata,
  output logic                        pready,
  output hs5_pkg::cfg_t               cfg
);
  import hs5_pkg::*;

  logic [2:0] index;
  logic       wr_en;

  assign index  = paddr[4:2];
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.coef_x     <= '0;
      cfg.coef_y     <= '0;
      cfg.grid_rows  <= GRID_RESET;
      cfg.grid_cols  <= GRID_RESET;
      cfg.halo_width <= HALO_RESET;
    end else if (wr_en) begin
      case (index)
        REG_COEF_X:     cfg.coef_x     <= pwdata[COEF_W-1:0];
        REG_COEF_Y:     cfg.coef_y     <= pwdata[COEF_W-1:0];
        REG_GRID_ROWS:  cfg.grid_rows  <= pwdata[GRID_W-1:0];
        REG_GRID_COLS:  cfg.grid_cols  <= pwdata[GRID_W-1:0];
        REG_HALO_WIDTH: cfg.halo_width <= pwdata[HALO_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (index)
      REG_COEF_X:     prdata = PDATA_W'(cfg.coef_x);
      REG_COEF_Y:     prdata = PDATA_W'(cfg.coef_y);
      REG_GRID_ROWS:  prdata = PDATA_W'(cfg.grid_rows);
      REG_GRID_COLS:  prdata = PDATA_W'(cfg.grid_cols);
      REG_HALO_WIDTH: prdata = PDATA_W'(cfg.halo_width);
      default:        prdata = '0;
    endcase
  end

endmodule

/* hw/rtl/hs5_front.sv */
`timescale 1ns / 1ps

module hs5_front #(
  parameter int MAX_ROWS = hs5_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = hs5_pkg::MAX_COLS_DEF,
  parameter int DEPTH    = hs5_pkg::QUEUE_DEPTH
) (
  input  logic                             clk,
  input  logic                             rst,
  input  hs5_pkg::cfg_t                    cfg,
  input  logic signed [hs5_pkg::DATA_W-1:0] sample,
  input  logic                             sample_valid,
  output logic                             sample_stall,
  output logic                             push,
  output hs5_pkg::work_t                   push_data,
  input  logic [$clog2(DEPTH+1)-1:0]       q_count
);
  import hs5_pkg::*;

  localparam int RIW = $clog2(MAX_ROWS);
  localparam int CIW = $clog2(MAX_COLS);
  localparam int RW  = $clog2(MAX_ROWS + 1);
  localparam int CLW = $clog2(MAX_COLS + 1);
  localparam int DW  = (RW > CLW) ? RW : CLW;
  localparam int CW  = ((DW > GRID_W) ? DW : GRID_W) + 1;
  localparam int QCW = $clog2(DEPTH + 1) + 1;

  logic [RIW-1:0] row_count;
  logic [CIW-1:0] col_count;

  logic [HALO_W-1:0] h;
  logic [CW-1:0]     rows_c, cols_c, h_ext, r_ext, i_ext, j_ext, col_inc, row_inc;
  logic              interior, is_last, wrap_col, wrap_row, accept;
  logic [CIW-1:0]    col_nb;

  logic              s1_valid, s1_emit, s1_last;
  logic [DATA_W-1:0] s1_sample;
  logic [IDX_W-1:0]  s1_row, s1_col;
  logic [CIW-1:0]    s1_addr;
  logic [DATA_W-1:0] above_q, above2_q, rn_q, left_above;

  logic [DATA_W-1:0] prev_row [MAX_COLS];
  logic [DATA_W-1:0] prev2_row [MAX_COLS];

  always_comb begin
    h = (cfg.halo_width == '0) ? HALO_RESET : cfg.halo_width;
    if (CW'(cfg.grid_rows) < CW'(MIN_DIM))       rows_c = CW'(MIN_DIM);
    else if (CW'(cfg.grid_rows) > CW'(MAX_ROWS)) rows_c = CW'(MAX_ROWS);
    else                                         rows_c = CW'(cfg.grid_rows);
    if (CW'(cfg.grid_cols) < CW'(MIN_DIM))       cols_c = CW'(MIN_DIM);
    else if (CW'(cfg.grid_cols) > CW'(MAX_COLS)) cols_c = CW'(MAX_COLS);
    else                                         cols_c = CW'(cfg.grid_cols);
    h_ext = CW'(h);
    r_ext = CW'(row_count);
    j_ext = CW'(col_count);
    i_ext = r_ext - CW'(1);
    interior = (row_count != '0) && ((h_ext << 1) < rows_c) && ((h_ext << 1) < cols_c) &&
               (i_ext >= h_ext) && (i_ext < rows_c - h_ext) &&
               (j_ext >= h_ext) && (j_ext < cols_c - h_ext);
    is_last  = (i_ext == rows_c - h_ext - CW'(1)) && (j_ext == cols_c - h_ext - CW'(1));
    col_inc  = j_ext + CW'(1);
    row_inc  = r_ext + CW'(1);
    wrap_col = col_inc >= cols_c;
    wrap_row = row_inc >= rows_c;
    col_nb   = (col_count == CIW'(MAX_COLS - 1)) ? '0 : CIW'(col_inc);
  end

  // room is reserved for the item in the read stage
  assign sample_stall = (QCW'(q_count) + QCW'(s1_valid && s1_emit)) >= QCW'(DEPTH);
  assign accept       = sample_valid && !sample_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= '0;
      col_count <= '0;
    end else if (accept) begin
      if (wrap_col) begin
        col_count <= '0;
        row_count <= wrap_row ? '0 : RIW'(row_inc);
      end else begin
        col_count <= CIW'(col_inc);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      above_q            <= prev_row[col_count];
      rn_q               <= prev_row[col_nb];
      prev_row[col_count] <= sample;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid) prev2_row[s1_addr] <= above_q;
    if (accept)   above2_q <= prev2_row[col_count];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid   <= 1'b0;
      s1_emit    <= 1'b0;
      left_above <= '0;
    end else begin
      s1_valid <= accept;
      s1_emit  <= accept && interior;
      if (s1_valid) left_above <= above_q;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_sample <= sample;
      s1_row    <= IDX_W'(i_ext);
      s1_col    <= IDX_W'(j_ext);
      s1_last   <= is_last;
      s1_addr   <= col_count;
    end
  end

  assign push = s1_valid && s1_emit;

  always_comb begin
    push_data.sample      = s1_sample;
    push_data.above       = above_q;
    push_data.above2      = above2_q;
    push_data.right_above = rn_q;
    push_data.left_above  = left_above;
    push_data.row         = s1_row;
    push_data.col         = s1_col;
    push_data.last        = s1_last;
  end

endmodule

/* hw/rtl/hs5_fifo.sv */
`timescale 1ns / 1ps

module hs5_fifo #(
  parameter int DEPTH = hs5_pkg::QUEUE_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  hs5_pkg::work_t             push_data,
  input  logic                       pop,
  output hs5_pkg::work_t             pop_data,
  output logic                       empty,
  output logic [$clog2(DEPTH+1)-1:0] count
);
  import hs5_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  work_t         entries [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic          do_pop;

  assign empty    = (count == '0);
  assign do_pop   = pop && !empty;
  assign pop_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push)   wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (do_pop) rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      case ({push, do_pop})
        2'b10:   count <= count + NW'(1);
        2'b01:   count <= count - NW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

/* hw/rtl/hs5_back.sv */
`timescale 1ns / 1ps

module hs5_back (
  input  logic                              clk,
  input  logic                              rst,
  input  hs5_pkg::cfg_t                     cfg,
  input  hs5_pkg::work_t                    q_data,
  input  logic                              q_empty,
  output logic                              q_pop,
  output logic signed [hs5_pkg::DATA_W-1:0] new_value,
  output logic [hs5_pkg::IDX_W-1:0]         row,
  output logic [hs5_pkg::IDX_W-1:0]         col,
  output logic                              last,
  output logic                              result_valid,
  input  logic                              result_stall
);
  import hs5_pkg::*;

  localparam int DW = DATA_W + 2;
  localparam int PW = DW + COEF_W + 1;
  localparam int RW = PW - 16;
  localparam int SW = RW + 2;
  localparam logic signed [SW-1:0] SAT_HI = SW'(64'sh7fffffff);
  localparam logic signed [SW-1:0] SAT_LO = SW'(-64'sh80000000);
  localparam logic signed [PW-1:0] HALF   = PW'(32768);

  typedef struct packed {
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic             last;
  } meta_t;

  logic adv;
  logic a_valid, b_valid, c_valid;
  meta_t a_meta, b_meta, c_meta;

  logic signed [DATA_W-1:0] a_c, b_c, c_c;
  logic signed [DW-1:0]     a_dx, a_dy, c2, dx, dy;
  logic signed [PW-1:0]     b_px, b_py, pxr, pyr;
  logic signed [RW-1:0]     c_rx, c_ry;
  logic signed [SW-1:0]     sum;

  assign adv   = !result_valid || !result_stall;
  assign q_pop = adv && !q_empty;

  always_comb begin
    c2  = DW'($signed(q_data.above)) <<< 1;
    dx  = DW'($signed(q_data.sample)) - c2 + DW'($signed(q_data.above2));
    dy  = DW'($signed(q_data.right_above)) - c2 + DW'($signed(q_data.left_above));
    pxr = b_px + HALF;
    pyr = b_py + HALF;
    sum = SW'(c_c) + SW'(c_rx) + SW'(c_ry);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid      <= 1'b0;
      b_valid      <= 1'b0;
      c_valid      <= 1'b0;
      result_valid <= 1'b0;
    end else if (adv) begin
      a_valid      <= !q_empty;
      b_valid      <= a_valid;
      c_valid      <= b_valid;
      result_valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_c    <= $signed(q_data.above);
      a_dx   <= dx;
      a_dy   <= dy;
      a_meta <= '{row: q_data.row, col: q_data.col, last: q_data.last};

      b_c    <= a_c;
      b_px   <= $signed({1'b0, cfg.coef_x}) * a_dx;
      b_py   <= $signed({1'b0, cfg.coef_y}) * a_dy;
      b_meta <= a_meta;

      // round half up, drop 16 fraction bits
      c_c    <= b_c;
      c_rx   <= $signed(pxr[PW-1:16]);
      c_ry   <= $signed(pyr[PW-1:16]);
      c_meta <= b_meta;

      if (sum > SAT_HI)      new_value <= SAT_HI[DATA_W-1:0];
      else if (sum < SAT_LO) new_value <= SAT_LO[DATA_W-1:0];
      else                   new_value <= sum[DATA_W-1:0];
      row  <= c_meta.row;
      col  <= c_meta.col;
      last <= c_meta.last;
    end
  end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import hs5_pkg::*;

  typedef struct {
    logic signed [DATA_W-1:0] value;
    logic [IDX_W-1:0]         row_i;
    logic [IDX_W-1:0]         col_i;
    logic                     is_last;
  } point_t;

  typedef enum {FILL_NOISE, FILL_SMOOTH, FILL_EXTREME} fill_e;

  localparam longint SAT_HI = 64'sd2147483647;
  localparam longint SAT_LO = -SAT_HI - 1;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic pready;
  logic signed [DATA_W-1:0] sample = '0;
  logic sample_valid = 1'b0;
  logic sample_stall;
  logic signed [DATA_W-1:0] new_value;
  logic [IDX_W-1:0] row;
  logic [IDX_W-1:0] col;
  logic last;
  logic result_valid;
  logic result_stall = 1'b0;

  // stencil state as the block should hold it
  logic [COEF_W-1:0] k_x = '0;
  logic [COEF_W-1:0] k_y = '0;
  logic [GRID_W-1:0] n_rows = GRID_RESET;
  logic [GRID_W-1:0] n_cols = GRID_RESET;
  logic [HALO_W-1:0] n_halo = HALO_RESET;
  logic signed [DATA_W-1:0] line_above [MAX_COLS_DEF];
  logic signed [DATA_W-1:0] line_above2 [MAX_COLS_DEF];
  logic signed [DATA_W-1:0] left_above = '0;
  int unsigned row_pos = 0;
  int unsigned col_pos = 0;

  logic signed [DATA_W-1:0] grid_feed [$];
  point_t updates_due [$];
  int unsigned items_queued = 0;
  int unsigned items_taken = 0;
  bit sample_taken = 1'b0;
  int errors = 0;
  int send_gap_pct = 0;
  int recv_stall_pct = 0;
  int hold_left = 0;
  int holds_asked = 0;
  int holds_done = 0;

  heat_stencil_5pt_step i_dut (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .sample       (sample),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .new_value    (new_value),
    .row          (row),
    .col          (col),
    .last         (last),
    .result_valid (result_valid),
    .result_stall (result_stall)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int unsigned eff_rows();
    return (n_rows < MIN_DIM) ? MIN_DIM : ((n_rows > MAX_ROWS_DEF) ? MAX_ROWS_DEF : n_rows);
  endfunction

  function automatic int unsigned eff_cols();
    return (n_cols < MIN_DIM) ? MIN_DIM : ((n_cols > MAX_COLS_DEF) ? MAX_COLS_DEF : n_cols);
  endfunction

  // k * d / 2^16, half rounds up
  function automatic longint round_q16(logic [COEF_W-1:0] k, longint d);
    return (longint'({1'b0, k}) * d + 32768) >>> 16;
  endfunction

  function automatic void stencil_step(logic signed [DATA_W-1:0] s);
    int unsigned nr, nc, h, i, j;
    logic signed [DATA_W-1:0] up, up2;
    longint ctr, sum;
    point_t pt;
    nr = eff_rows();
    nc = eff_cols();
    h = (n_halo == 0) ? 1 : n_halo;
    j = col_pos;
    up = line_above[j];
    up2 = line_above2[j];
    if (row_pos >= 1 && 2 * h < nr && 2 * h < nc) begin
      i = row_pos - 1;
      if (i >= h && i < nr - h && j >= h && j < nc - h) begin
        ctr = up;
        sum = ctr + round_q16(k_x, longint'(s) - 2 * ctr + up2)
                  + round_q16(k_y, longint'(line_above[j + 1]) - 2 * ctr + left_above);
        if (sum > SAT_HI) sum = SAT_HI;
        if (sum < SAT_LO) sum = SAT_LO;
        pt.value = sum[DATA_W-1:0];
        pt.row_i = i[IDX_W-1:0];
        pt.col_i = j[IDX_W-1:0];
        pt.is_last = (i == nr - h - 1) && (j == nc - h - 1);
        updates_due.push_back(pt);
      end
    end
    left_above = up;
    line_above2[j] = up;
    line_above[j] = s;
    col_pos = j + 1;
    if (col_pos >= nc) begin
      col_pos = 0;
      row_pos = row_pos + 1;
      if (row_pos >= nr) row_pos = 0;
    end
  endfunction

  always @(posedge clk) begin
    point_t want;
    sample_taken = 1'b0;
    if (!rst) begin
      if (result_valid && !result_stall) begin
        if (updates_due.size() == 0) begin
          $error("unexpected result: row %0d col %0d new_value %0d", row, col, new_value);
          errors++;
        end else begin
          want = updates_due.pop_front();
          if (new_value !== want.value) begin
            $error("new_value: expected %0d, got %0d", want.value, new_value);
            errors++;
          end
          if (row !== want.row_i) begin
            $error("row: expected %0d, got %0d", want.row_i, row);
            errors++;
          end
          if (col !== want.col_i) begin
            $error("col: expected %0d, got %0d", want.col_i, col);
            errors++;
          end
          if (last !== want.is_last) begin
            $error("last: expected %0b, got %0b", want.is_last, last);
            errors++;
          end
        end
      end
      if (sample_valid && !sample_stall) begin
        sample_taken = 1'b1;
        items_taken++;
        stencil_step(sample);
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      sample_valid <= 1'b0;
    end else if (!sample_valid || sample_taken) begin
      if (grid_feed.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
        sample <= grid_feed.pop_front();
        sample_valid <= 1'b1;
      end else begin
        sample_valid <= 1'b0;
      end
    end
  end

  // long hold-off on request, random stalls otherwise
  always @(negedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (holds_done != holds_asked) begin
      hold_left <= 400;
      holds_done <= holds_done + 1;
    end
    result_stall <= !rst && (hold_left != 0 || holds_done != holds_asked ||
                             $urandom_range(99) < recv_stall_pct);
  end

  task automatic program_grid(logic [COEF_W-1:0] kx, logic [COEF_W-1:0] ky,
                              logic [GRID_W-1:0] nr, logic [GRID_W-1:0] nc,
                              logic [HALO_W-1:0] h);
    logic [2:0] addr_idx [5];
    logic [PDATA_W-1:0] wval [5];
    addr_idx = '{REG_COEF_X, REG_COEF_Y, REG_GRID_ROWS, REG_GRID_COLS, REG_HALO_WIDTH};
    wval[0] = PDATA_W'(kx);
    wval[1] = PDATA_W'(ky);
    wval[2] = PDATA_W'(nr);
    wval[3] = PDATA_W'(nc);
    wval[4] = PDATA_W'(h);
    for (int k = 0; k < 5; k++) begin
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {addr_idx[k], 2'b00};
      pwdata <= wval[k];
      @(negedge clk);
      penable <= 1'b1;
      do @(posedge clk); while (!pready);
      case (addr_idx[k])
        REG_COEF_X:     k_x = wval[k][COEF_W-1:0];
        REG_COEF_Y:     k_y = wval[k][COEF_W-1:0];
        REG_GRID_ROWS:  n_rows = wval[k][GRID_W-1:0];
        REG_GRID_COLS:  n_cols = wval[k][GRID_W-1:0];
        REG_HALO_WIDTH: n_halo = wval[k][HALO_W-1:0];
        default: ;
      endcase
      @(negedge clk);
    end
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // returns at a falling edge once every item is taken and every update seen
  task automatic wait_idle();
    while (items_taken != items_queued || updates_due.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic queue_samples(int unsigned count);
    fill_e fill;
    logic signed [DATA_W-1:0] base, v;
    fill = fill_e'($urandom_range(2));
    base = $urandom;
    for (int unsigned k = 0; k < count; k++) begin
      case (fill)
        FILL_SMOOTH: v = base + $urandom_range(131072) - 65536;
        FILL_EXTREME: begin
          case ($urandom_range(3))
            0: v = 32'sh7FFFFFFF;
            1: v = 32'sh80000000;
            2: v = $urandom_range(2) - 1;
            default: v = $urandom;
          endcase
        end
        default: v = $urandom;
      endcase
      grid_feed.push_back(v);
      items_queued++;
    end
  endtask

  function automatic logic [COEF_W-1:0] pick_coef();
    case ($urandom_range(7))
      0: return '0;
      1: return 16'hFFFF;
      2: return 16'h8000;
      3: return 16'h0001;
      default: return COEF_W'($urandom_range(65535));
    endcase
  endfunction

  function automatic logic [GRID_W-1:0] pick_dim();
    return GRID_W'(($urandom_range(9) == 0) ? $urandom_range(2) : $urandom_range(3, 12));
  endfunction

  initial begin
    logic signed [DATA_W-1:0] corner [25];
    logic [HALO_W-1:0] h;
    int unsigned random_items, reps, r, c, tail;
    corner = '{0, 32'sh7FFFFFFF, 32'sh80000000, 1, -1,
               3, 32'sh7FFFFFFF, -5, 7, 32'sh80000000,
               32'sh80000000, 32'sh80000000, 32'sh7FFFFFFF, -3, 9,
               11, 2, 32'sh80000000, 32'sh7FFFFFFF, 0,
               -7, 32'sh7FFFFFFF, 1, 32'sh80000000, 5};
    random_items = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    send_gap_pct = 24;
    recv_stall_pct = 87;

    // halo 0 behaves as 1; odd differences give rounding ties, extremes saturate
    program_grid(16'h8000, 16'h8000, 11'd5, 11'd5, 4'd0);
    foreach (corner[k]) begin
      grid_feed.push_back(corner[k]);
      items_queued++;
    end
    wait_idle();
    // undersized grid clamps to 3 x 3
    program_grid(16'hFFFF, 16'hFFFF, 11'd0, 11'd2, 4'd1);
    queue_samples(9);
    wait_idle();
    program_grid(16'h0001, 16'h0000, 11'd5, 11'd5, 4'd2);
    queue_samples(25);
    wait_idle();
    // no interior point at all
    program_grid(16'h1234, 16'hABCD, 11'd5, 11'd5, 4'd15);
    queue_samples(25);
    wait_idle();

    // top rows of the tallest grid (row count clamped) under a long output hold-off
    program_grid(pick_coef(), pick_coef(), 11'd2047, 11'd3, 4'd1);
    queue_samples(300);
    holds_asked++;
    wait_idle();

    send_gap_pct = 87;
    recv_stall_pct = 24;
    // reconfiguration part way through a grid
    program_grid(16'h1234, 16'h4321, 11'd8, 11'd8, 4'd1);
    queue_samples(28);
    wait_idle();
    program_grid(16'hFFFF, 16'h0100, 11'd5, 11'd8, 4'd1);
    queue_samples(10);
    wait_idle();
    // both counters now at or past the new bounds
    program_grid(16'h0800, 16'hC000, 11'd4, 11'd5, 4'd1);
    r = row_pos;
    c = col_pos;
    tail = 0;
    do begin
      c++;
      tail++;
      if (c >= eff_cols()) begin
        c = 0;
        r++;
        if (r >= eff_rows()) r = 0;
      end
    end while (r != 0 || c != 0);
    queue_samples(tail);
    wait_idle();

    while (random_items < 750) begin
      if (random_items >= 375) begin
        send_gap_pct = 0;
        recv_stall_pct = 0;
      end
      case ($urandom_range(9))
        0: h = '0;
        1, 2: h = HALO_W'($urandom_range(3, 15));
        default: h = HALO_W'($urandom_range(1, 2));
      endcase
      program_grid(pick_coef(), pick_coef(), pick_dim(), pick_dim(), h);
      reps = $urandom_range(1, 3);
      repeat (reps) begin
        queue_samples(eff_rows() * eff_cols());
        random_items += eff_rows() * eff_cols();
        if ($urandom_range(7) == 0) wait_idle();
      end
      wait_idle();
    end

    wait_idle();
    if (errors == 0 && updates_due.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("tb_top: FAIL");
    $finish;
  end

endmodule

/* heat_stencil_5pt_step.f */
hw/rtl/hs5_pkg.sv
hw/rtl/hs5_cfg.sv
hw/rtl/hs5_front.sv
hw/rtl/hs5_fifo.sv
hw/rtl/hs5_back.sv
hw/rtl/heat_stencil_5pt_step.sv
tb/tb_top.sv
